// ----- hw/rtl/qnc_pkg.sv -----
package qnc_pkg;

   localparam int MaxLevels = 16;
   localparam int CoordW    = 16;
   localparam int CodeW     = 32;
   localparam int NumCand   = 16;
   localparam int NumSlots  = 12;

   typedef logic [CoordW-1:0] coord_type;
   typedef logic [CodeW-1:0]  code_type;
   typedef logic [4:0]        level_type;
   typedef logic [3:0]        rank_type;
   typedef logic [4:0]        total_type;

   // rows to odd bits, columns to even bits
   function automatic code_type morton(input coord_type row, input coord_type col);
      code_type code;
      code = '0;
      for (int b = 0; b < CoordW; b++) begin
         code[2*b+1] = row[b];
         code[2*b]   = col[b];
      end
      return code;
   endfunction

endpackage

// ----- hw/rtl/quadtree_neighbor_code_generator.sv -----
// channel | dir | signals                        | content
// req     | in  | req_tvalid/tready/tdata[39:0]  | cell_level, cell_row, cell_column
// rsp     | out | rsp_tvalid/tready/tdata/tuser/tlast | neighbor_code, none_found, last
// csr     | in  | csr_valid/ready/data[4:0]      | deepest_level, always ready
// Five register stages then an output shift register; a request enters each
// cycle unless the pipeline holds, and yields 1 to 12 responses at one per
// cycle while rsp_tready is high.
// Synchronous active-high reset clears valid bits and sets deepest_level to 16.
// The whole pipeline holds while the output has responses left to hand over.
module quadtree_neighbor_code_generator import qnc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [4:0] cell_level, [20:5] cell_row, [36:21] cell_column
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] neighbor_code
   output logic        rsp_tuser,   // [0] none_found
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // [4:0] deepest_level
);

   logic [4:0] deep_ff;
   logic       adv;

   // stage 1
   logic              s1_v_ff;
   coord_type         s1_r_ff, s1_c_ff, s1_h2_ff;
   logic [CoordW:0]   s1_h_ff;
   logic              s1_lb_ff, s1_rb_ff, s1_db_ff, s1_ub_ff, s1_fine_ff, s1_par_ff;
   // stage 2
   logic                   s2_v_ff;
   code_type               s2_cand_ff [NumCand];
   logic [NumCand-1:0]     s2_cv_ff;
   // stage 3
   logic                   s3_v_ff;
   code_type               s3_cand_ff [NumCand];
   logic [NumCand-1:0]     s3_cv_ff;
   logic [NumCand-1:0]     s3_lt_ff [NumCand];  // [j][i]: cand j < cand i
   logic [NumCand-1:0]     s3_eq_ff [NumCand];
   // stage 4
   logic                   s4_v_ff;
   code_type               s4_cand_ff [NumCand];
   logic [NumCand-1:0]     s4_keep_ff;
   logic [NumCand-1:0]     s4_lt_ff [NumCand];
   // stage 5
   logic                   s5_v_ff;
   code_type               s5_cand_ff [NumCand];
   logic [NumCand-1:0]     s5_keep_ff;
   rank_type               s5_rank_ff [NumCand];
   total_type              s5_total_ff;
   // output
   logic                   e_v_ff;
   code_type               e_code_ff [NumSlots];
   logic [3:0]             e_cnt_ff;
   logic                   e_none_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deep_ff <= 5'd16;
      end else if (csr_valid) begin
         deep_ff <= csr_data;
      end
   end

   assign adv        = !e_v_ff || (rsp_tready && e_cnt_ff == 4'd1);
   assign req_tready = adv;

   // stage 1: clamp, align, border flags
   level_type       d_c, lvl_c, lin_c;
   logic [CoordW:0] h_c, side_c;
   coord_type       r_c, c_c, msk_c;

   always_comb begin
      d_c = deep_ff;
      if (d_c < 5'd1) d_c = 5'd1;
      if (d_c > 5'(MaxLevels)) d_c = 5'(MaxLevels);
      lin_c = req_tdata[4:0];
      lvl_c = (lin_c > d_c) ? d_c : lin_c;
      side_c = (CoordW+1)'(1) << d_c;
      h_c    = (CoordW+1)'(1) << (d_c - lvl_c);
      msk_c  = CoordW'(side_c - 1'b1) & ~CoordW'(h_c - 1'b1);
      r_c    = req_tdata[20:5] & msk_c;
      c_c    = req_tdata[36:21] & msk_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_r_ff    <= r_c;
         s1_c_ff    <= c_c;
         s1_h_ff    <= h_c;
         s1_h2_ff   <= CoordW'(h_c >> 1);
         s1_lb_ff   <= {1'b0, c_c} < h_c;
         s1_rb_ff   <= ({1'b0, c_c} + h_c) >= side_c;
         s1_db_ff   <= {1'b0, r_c} < h_c;
         s1_ub_ff   <= ({1'b0, r_c} + h_c) >= side_c;
         s1_fine_ff <= lvl_c < d_c;
         s1_par_ff  <= lvl_c > 5'd1;
      end
   end

   // stage 2: candidate codes
   code_type           cand_c [NumCand];
   logic [NumCand-1:0] cv_c;
   coord_type          hl_c, h2x_c, pr_c, pc_c;

   always_comb begin
      hl_c  = s1_h_ff[CoordW-1:0];
      h2x_c = {s1_h_ff[CoordW-2:0], 1'b0};
      pr_c  = s1_r_ff & ~hl_c;
      pc_c  = s1_c_ff & ~hl_c;
      cand_c[0]  = morton(s1_r_ff + s1_h2_ff, s1_c_ff - s1_h2_ff);
      cand_c[1]  = morton(s1_r_ff,            s1_c_ff - s1_h2_ff);
      cand_c[2]  = morton(s1_r_ff + s1_h2_ff, s1_c_ff + hl_c);
      cand_c[3]  = morton(s1_r_ff,            s1_c_ff + hl_c);
      cand_c[4]  = morton(s1_r_ff + hl_c,     s1_c_ff);
      cand_c[5]  = morton(s1_r_ff + hl_c,     s1_c_ff + s1_h2_ff);
      cand_c[6]  = morton(s1_r_ff - s1_h2_ff, s1_c_ff);
      cand_c[7]  = morton(s1_r_ff - s1_h2_ff, s1_c_ff + s1_h2_ff);
      cand_c[8]  = morton(s1_r_ff,            s1_c_ff - hl_c);
      cand_c[9]  = morton(s1_r_ff,            s1_c_ff + hl_c);
      cand_c[10] = morton(s1_r_ff - hl_c,     s1_c_ff);
      cand_c[11] = morton(s1_r_ff + hl_c,     s1_c_ff);
      cand_c[12] = morton(pr_c,               pc_c - h2x_c);
      cand_c[13] = morton(pr_c,               pc_c + h2x_c);
      cand_c[14] = morton(pr_c + h2x_c,       pc_c);
      cand_c[15] = morton(pr_c - h2x_c,       pc_c);
      cv_c[0]  = s1_fine_ff && !s1_lb_ff;
      cv_c[1]  = s1_fine_ff && !s1_lb_ff;
      cv_c[2]  = s1_fine_ff && !s1_rb_ff;
      cv_c[3]  = s1_fine_ff && !s1_rb_ff;
      cv_c[4]  = s1_fine_ff && !s1_ub_ff;
      cv_c[5]  = s1_fine_ff && !s1_ub_ff;
      cv_c[6]  = s1_fine_ff && !s1_db_ff;
      cv_c[7]  = s1_fine_ff && !s1_db_ff;
      cv_c[8]  = !s1_lb_ff;
      cv_c[9]  = !s1_rb_ff;
      cv_c[10] = !s1_db_ff;
      cv_c[11] = !s1_ub_ff;
      cv_c[12] = s1_par_ff && !s1_lb_ff && (s1_c_ff & hl_c) == '0;
      cv_c[13] = s1_par_ff && !s1_rb_ff && (s1_c_ff & hl_c) != '0;
      cv_c[14] = s1_par_ff && !s1_ub_ff && (s1_r_ff & hl_c) != '0;
      cv_c[15] = s1_par_ff && !s1_db_ff && (s1_r_ff & hl_c) == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   // stage 3: pairwise compares
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_cand_ff <= cand_c;
         s2_cv_ff   <= cv_c;
         s3_cand_ff <= s2_cand_ff;
         s3_cv_ff   <= s2_cv_ff;
         for (int j = 0; j < NumCand; j++) begin
            for (int i = 0; i < NumCand; i++) begin
               s3_lt_ff[j][i] <= s2_cand_ff[j] < s2_cand_ff[i];
               s3_eq_ff[j][i] <= s2_cand_ff[j] == s2_cand_ff[i];
            end
         end
      end
   end

   // stage 4: drop duplicates, keep the first of each value
   logic [NumCand-1:0] keep_c;

   always_comb begin
      for (int i = 0; i < NumCand; i++) begin
         keep_c[i] = s3_cv_ff[i];
         for (int j = 0; j < i; j++) begin
            if (s3_cv_ff[j] && s3_eq_ff[j][i]) keep_c[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_cand_ff <= s3_cand_ff;
         s4_keep_ff <= keep_c;
         s4_lt_ff   <= s3_lt_ff;
      end
   end

   // stage 5: rank among kept values
   logic [NumCand-1:0] col_c [NumCand];

   always_comb begin
      for (int i = 0; i < NumCand; i++) begin
         for (int j = 0; j < NumCand; j++) begin
            col_c[i][j] = s4_keep_ff[j] && s4_lt_ff[j][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_cand_ff  <= s4_cand_ff;
         s5_keep_ff  <= s4_keep_ff;
         s5_total_ff <= 5'($countones(s4_keep_ff));
         for (int i = 0; i < NumCand; i++) begin
            s5_rank_ff[i] <= 4'($countones(col_c[i]));
         end
      end
   end

   // scatter into response slots
   code_type   slot_c [NumSlots];
   logic [3:0] cnt_c;

   always_comb begin
      for (int k = 0; k < NumSlots; k++) begin
         slot_c[k] = '0;
         for (int i = 0; i < NumCand; i++) begin
            if (s5_keep_ff[i] && s5_rank_ff[i] == 4'(k)) slot_c[k] = s5_cand_ff[i];
         end
      end
      if (s5_total_ff == '0) begin
         cnt_c = 4'd1;
      end else if (s5_total_ff > 5'(NumSlots)) begin
         cnt_c = 4'(NumSlots);
      end else begin
         cnt_c = s5_total_ff[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_code_ff <= slot_c;
         e_cnt_ff  <= cnt_c;
         e_none_ff <= s5_total_ff == '0;
      end else if (rsp_tready) begin
         for (int k = 0; k < NumSlots - 1; k++) begin
            e_code_ff[k] <= e_code_ff[k+1];
         end
         e_cnt_ff <= e_cnt_ff - 4'd1;
      end
   end

   assign rsp_tvalid = e_v_ff;
   assign rsp_tdata  = e_code_ff[0];
   assign rsp_tuser  = e_none_ff;
   assign rsp_tlast  = e_cnt_ff == 4'd1;

   a_none_is_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("none response not a single zero code");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while output stalled");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tdata > $past(rsp_tdata))
      else $error("codes within a run not ascending");

endmodule

// ----- tb/tb_quadtree_neighbor_code_generator.sv -----
module tb_quadtree_neighbor_code_generator import qnc_pkg::*; ();

   typedef struct packed {
      logic [4:0]  level;
      logic [15:0] row;
      logic [15:0] column;
   } cell_query_type;

   typedef struct packed {
      logic [31:0] code;
      logic        none;
      logic        last;
   } neighbor_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data = '0;

   cell_query_type pending_cells[$];
   neighbor_type   expected_neighbors[$];
   logic [4:0]  deepest_reg = 5'd16;
   int          fail_count = 0;
   int          requests_sent = 0;
   int          responses_seen = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          hold_off = 0;
   bit          long_hold_req = 1'b0;
   int          stall_mode = 0;

   quadtree_neighbor_code_generator i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] interleave(logic [63:0] r, logic [63:0] c, int d);
      logic [63:0] v;
      v = '0;
      for (int b = 0; b < d; b++) begin
         v[2*b+1] = r[b];
         v[2*b]   = c[b];
      end
      return v;
   endfunction

   // predicted neighbour list for one cell, appended to expected_neighbors
   function automatic void predict_neighbors(cell_query_type q);
      logic [63:0] cand[$];
      logic [63:0] uniq[$];
      logic [63:0] side, h, h2, r, c, pr, pc;
      int d, lvl, n;
      bit lb, rb, db, ub;
      neighbor_type e;
      d = deepest_reg;
      if (d < 1) d = 1;
      if (d > MaxLevels) d = MaxLevels;
      lvl = q.level;
      if (lvl > d) lvl = d;
      side = 64'd1 << d;
      h = 64'd1 << (d - lvl);
      h2 = h >> 1;
      r = {48'd0, q.row} & (side - 1) & ~(h - 1);
      c = {48'd0, q.column} & (side - 1) & ~(h - 1);
      lb = c < h;
      rb = c + h >= side;
      db = r < h;
      ub = r + h >= side;
      if (lvl < d) begin
         if (!lb) begin
            cand = {cand, interleave(r + h2, c - h + h2, d)};
            cand = {cand, interleave(r, c - h + h2, d)};
         end
         if (!rb) begin
            cand = {cand, interleave(r + h2, c + h, d)};
            cand = {cand, interleave(r, c + h, d)};
         end
         if (!ub) begin
            cand = {cand, interleave(r + h, c, d)};
            cand = {cand, interleave(r + h, c + h2, d)};
         end
         if (!db) begin
            cand = {cand, interleave(r - h + h2, c, d)};
            cand = {cand, interleave(r - h + h2, c + h2, d)};
         end
      end
      if (!lb) cand = {cand, interleave(r, c - h, d)};
      if (!rb) cand = {cand, interleave(r, c + h, d)};
      if (!db) cand = {cand, interleave(r - h, c, d)};
      if (!ub) cand = {cand, interleave(r + h, c, d)};
      if (lvl > 1) begin
         pr = r & ~h;
         pc = c & ~h;
         if (!lb && (c & h) == 0) cand = {cand, interleave(pr, pc - 2*h, d)};
         if (!rb && (c & h) != 0) cand = {cand, interleave(pr, pc + 2*h, d)};
         if (!ub && (r & h) != 0) cand = {cand, interleave(pr + 2*h, pc, d)};
         if (!db && (r & h) == 0) cand = {cand, interleave(pr - 2*h, pc, d)};
      end
      if (cand.size() == 0) begin
         e.code = '0;
         e.none = 1'b1;
         e.last = 1'b1;
         expected_neighbors = {expected_neighbors, e};
         return;
      end
      cand.sort();
      foreach (cand[k])
         if (uniq.size() == 0 || uniq[$] != cand[k]) uniq = {uniq, cand[k]};
      n = uniq.size() > NumSlots ? NumSlots : uniq.size();
      for (int k = 0; k < n; k++) begin
         e.code = uniq[k][31:0];
         e.none = 1'b0;
         e.last = (k == n - 1);
         expected_neighbors = {expected_neighbors, e};
      end
   endfunction

   // sender: bursts with gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) requests_sent++;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cells.size() > 0) begin
            cell_query_type q;
            q = pending_cells.pop_front();
            predict_neighbors(q);
            req_tdata <= {3'd0, q.column, q.row, q.level};
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_off = 300;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 1) == 1);
         endcase
         if ($urandom_range(0, 40) == 0) stall_mode = $urandom_range(0, 2);
      end
   end

   // checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         neighbor_type e;
         responses_seen++;
         if (expected_neighbors.size() == 0) begin
            $error("unexpected response code %h", rsp_tdata);
            fail_count++;
         end else begin
            e = expected_neighbors.pop_front();
            if (rsp_tdata !== e.code) begin
               $error("neighbor_code exp %h got %h", e.code, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== e.none) begin
               $error("none_found exp %0b got %0b", e.none, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_of_run exp %0b got %0b", e.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   task automatic write_deepest(logic [4:0] v);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      deepest_reg = v;
   endtask

   task automatic drain();
      while (pending_cells.size() > 0 || req_tvalid || expected_neighbors.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic cell_query_type random_cell(int d);
      cell_query_type q;
      int lvl;
      logic [15:0] m;
      lvl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, d);
      q.level = 5'(lvl);
      q.row = 16'($urandom);
      q.column = 16'($urandom);
      if ($urandom_range(0, 3) != 0 && lvl <= d) begin
         m = 16'((16'hFFFF << (d - lvl)) & ((17'h1 << d) - 1));
         q.row &= m;
         q.column &= m;
      end
      return q;
   endfunction

   task automatic add_cell(int l, int r, int c);
      pending_cells = {pending_cells, cell_query_type'{5'(l), 16'(r), 16'(c)}};
   endtask

   int dlist[6] = '{16, 1, 3, 0, 31, 8};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed, reset value of deepest level
      add_cell(0, 0, 0);
      add_cell(1, 0, 0);
      add_cell(1, 16'h8000, 16'h8000);
      add_cell(2, 16'h4000, 16'h4000);
      add_cell(16, 0, 0);
      add_cell(16, 16'hFFFF, 16'hFFFF);
      add_cell(16, 16'h1234, 16'h5678);
      add_cell(15, 16'h2222, 16'hAAAA);
      add_cell(31, 16'hFFFF, 0);
      add_cell(3, 16'hFFFF, 16'h5555);
      add_cell(5, 16'h0800, 16'hF800);
      add_cell(8, 16'h7F00, 16'h8100);
      drain();
      foreach (dlist[i]) begin
         write_deepest(5'(dlist[i]));
         add_cell(0, 0, 0);
         add_cell(1, 16'hFFFF, 16'hFFFF);
         add_cell(31, 16'hFFFF, 16'hFFFF);
         for (int k = 0; k < 32; k++) pending_cells = {pending_cells, random_cell(
            dlist[i] < 1 ? 1 : (dlist[i] > 16 ? 16 : dlist[i]))};
         if (i == 1) begin
            wait (requests_sent > 0);
            long_hold_req = 1'b1;
         end
         drain();
      end
      $display("covered %0d requests, %0d responses, over %0d deepest-level settings",
               requests_sent, responses_seen, 7);
      if (fail_count == 0)
         $display("tb_quadtree_neighbor_code_generator: PASS");
      else
         $display("tb_quadtree_neighbor_code_generator: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_quadtree_neighbor_code_generator: FAIL");
      $finish;
   end
endmodule
